// ----- sv/gsagu_pkg.sv -----
// shared types and codes of the take/put along axis address generator
package gsagu_pkg;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_INDEX = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_IDLE  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_GATHER_MODE    = 3'd0,
    REG_RANK           = 3'd1,
    REG_AXIS           = 3'd2,
    REG_AXIS_LENGTH    = 3'd3,
    REG_WALK_SHAPE     = 3'd4,
    REG_ARRAY_STRIDES  = 3'd5,
    REG_INDEX_STRIDES  = 3'd6,
    REG_STREAM_STRIDES = 3'd7
  } reg_e;

  typedef struct packed {
    logic [2:0]  rank;
    logic [1:0]  axis;
    logic [15:0] axis_length;
    logic [63:0] walk_shape;
    logic [63:0] array_strides;
    logic [63:0] index_strides;
    logic [63:0] stream_strides;
  } cfg_t;

  typedef struct packed {
    logic [31:0] index_offset;
    logic [31:0] array_offset;
    logic [31:0] stream_offset;
    logic        transfer_valid;
    logic        last;
    status_e     status;
    logic [31:0] error_index;
  } result_t;

endpackage

// ----- sv/gather_scatter_along_axis_agu_unit.sv -----
// top level of the take/put along axis address generator
//
//  channel   dir  handshake                       content
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tuser kind, tdata raw index
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i  one address set per request, tlast end of job
//  cfg       in   cfg_valid_i/cfg_ready_o          register index and 64-bit write data
//
// one request per cycle sustained while the output does not stall; an accepted request
// waits in the input register, and its result loads from there into the result buffer
// reset clears the register bank, the valid flags and the walk state, the block starts idle
// a two-entry result buffer absorbs output stalls; s_axis_tready_o drops only
// when that buffer is full and the input register holds a request
module gather_scatter_along_axis_agu_unit #(
  parameter int MAX_RANK    = 4,
  parameter int OFFSET_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,   // raw_index
  input  logic         s_axis_tuser_i,   // kind
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,   // index_offset, array_offset, stream_offset, error_index
  output logic [2:0]   m_axis_tuser_o,   // transfer_valid, status[1:0]
  output logic         m_axis_tlast_o,   // last
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);

  gsagu_pkg::cfg_t    cfg_q;
  gsagu_pkg::result_t res, out_q, skid_q;
  logic               out_valid_q, skid_valid_q;
  logic               a_valid_q, a_kind_q;
  logic [31:0]        a_raw_q;
  logic               s_fire, advance, pop, load_skid;

  assign cfg_ready_o = 1'b1;

  // take/put selection changes nothing in the addresses, so it is not stored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (gsagu_pkg::reg_e'(cfg_index_i))
        gsagu_pkg::REG_GATHER_MODE:    ;
        gsagu_pkg::REG_RANK:           cfg_q.rank           <= cfg_data_i[2:0];
        gsagu_pkg::REG_AXIS:           cfg_q.axis           <= cfg_data_i[1:0];
        gsagu_pkg::REG_AXIS_LENGTH:    cfg_q.axis_length    <= cfg_data_i[15:0];
        gsagu_pkg::REG_WALK_SHAPE:     cfg_q.walk_shape     <= cfg_data_i;
        gsagu_pkg::REG_ARRAY_STRIDES:  cfg_q.array_strides  <= cfg_data_i;
        gsagu_pkg::REG_INDEX_STRIDES:  cfg_q.index_strides  <= cfg_data_i;
        gsagu_pkg::REG_STREAM_STRIDES: cfg_q.stream_strides <= cfg_data_i;
      endcase
    end
  end

  assign advance         = a_valid_q && !skid_valid_q;
  assign s_axis_tready_o = !a_valid_q || !skid_valid_q;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = out_valid_q && m_axis_tready_i;
  assign load_skid       = advance && out_valid_q && !pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      a_valid_q    <= s_fire || (a_valid_q && !advance);
      out_valid_q  <= advance || skid_valid_q || (out_valid_q && !pop);
      skid_valid_q <= skid_valid_q ? !pop : load_skid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      a_kind_q <= s_axis_tuser_i;
      a_raw_q  <= s_axis_tdata_i;
    end
    if (pop && skid_valid_q) begin
      out_q <= skid_q;
    end else if (advance && (pop || !out_valid_q)) begin
      out_q <= res;
    end
    if (load_skid) begin
      skid_q <= res;
    end
  end

  gsagu_walk #(
    .MAX_RANK    (MAX_RANK),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (advance),
    .kind_i      (a_kind_q),
    .raw_index_i (a_raw_q),
    .res_o       (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.error_index, out_q.stream_offset,
                            out_q.array_offset, out_q.index_offset};
  assign m_axis_tuser_o  = {out_q.status, out_q.transfer_valid};
  assign m_axis_tlast_o  = out_q.last;

`ifndef SYNTHESIS
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while head is empty");

  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced request has no result");

  a_stall_keeps_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !m_axis_tready_i) |=> (skid_valid_q && $stable(skid_q)))
    else $error("skid entry lost during output stall");
`endif

endmodule

// ----- sv/gsagu_walk.sv -----
// walk state, index bound check and offset arithmetic for one request per cycle
module gsagu_walk #(
  parameter int MAX_RANK    = 4,
  parameter int OFFSET_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gsagu_pkg::cfg_t     cfg_i,
  input  logic                step_i,
  input  logic                kind_i,
  input  logic [31:0]         raw_index_i,
  output gsagu_pkg::result_t  res_o
);

  localparam int OB = OFFSET_BITS;

  function automatic logic [15:0] lane16(input logic [63:0] packed_v, input logic [1:0] d);
    return packed_v[16*d +: 16];
  endfunction

  function automatic logic [OB-1:0] to_ofs(input logic [15:0] s);
    logic [63:0] w;
    w = {{48{s[15]}}, s};
    return w[OB-1:0];
  endfunction

  // extent minus one times a signed stride, the distance a rewind jumps back
  function automatic logic [OB-1:0] rewind(input logic [15:0] n, input logic [15:0] s);
    logic signed [32:0] p;
    logic [63:0]        w;
    p = $signed({1'b0, n}) * $signed(s);
    w = 64'(p);
    return w[OB-1:0];
  endfunction

  function automatic logic [31:0] out_ofs(input logic [OB-1:0] x);
    logic [63:0] w;
    w = 64'($signed(x));
    return w[31:0];
  endfunction

  // positions move by stride steps and rewinds, so a stride change mid-job acts at once
  logic [15:0]   coord_q   [MAX_RANK];
  logic [OB-1:0] idx_pos_q, str_pos_q, arr_base_q;
  logic          running_q;

  logic [15:0]   coord_n   [MAX_RANK];
  logic [OB-1:0] idx_dlt   [MAX_RANK];
  logic [OB-1:0] str_dlt   [MAX_RANK];
  logic [OB-1:0] arr_dlt   [MAX_RANK];
  logic [15:0]   ext       [MAX_RANK];
  logic [15:0]   ext_m1    [MAX_RANK];
  logic [15:0]   arr_lane  [MAX_RANK];
  logic          active    [MAX_RANK];
  logic [OB-1:0] idx_pos_n, str_pos_n, arr_base_n;
  logic [2:0]    eff_rank;
  logic          empty, carry, done, in_range, is_start;
  logic signed [32:0] vsum;
  logic [15:0]   v16;
  logic signed [15:0] axs;
  logic signed [32:0] prod;
  logic [63:0]   prod_w;

  assign is_start = (kind_i == gsagu_pkg::KIND_START);

  always_comb begin
    eff_rank = (cfg_i.rank > 3'(MAX_RANK)) ? 3'(MAX_RANK) : cfg_i.rank;
    empty = (eff_rank == 3'd0) || (cfg_i.axis_length == 16'd0) ||
            ({1'b0, cfg_i.axis} >= eff_rank);
    for (int d = 0; d < MAX_RANK; d++) begin
      active[d] = (3'(d) < eff_rank);
      ext[d]    = lane16(cfg_i.walk_shape, 2'(d));
      if (active[d] && ext[d] == 16'd0) begin
        empty = 1'b1;
      end
    end
  end

  // negative index wraps once by the axis length, then must land in [0, length)
  always_comb begin
    vsum = {raw_index_i[31], raw_index_i} +
           (raw_index_i[31] ? {17'd0, cfg_i.axis_length} : 33'd0);
    in_range = !vsum[32] && (vsum[31:16] == 16'd0) && (vsum[15:0] < cfg_i.axis_length);
    v16 = vsum[15:0];
    axs = $signed(lane16(cfg_i.array_strides, cfg_i.axis));
    prod = $signed({1'b0, v16}) * axs;
    prod_w = 64'(prod);
  end

  // odometer: last active dimension fastest, carry ripples toward dimension 0
  always_comb begin
    carry = 1'b1;
    for (int d = MAX_RANK - 1; d >= 0; d--) begin
      coord_n[d]  = coord_q[d];
      idx_dlt[d]  = '0;
      str_dlt[d]  = '0;
      arr_dlt[d]  = '0;
      ext_m1[d]   = (ext[d] == 16'd0) ? 16'd0 : ext[d] - 16'd1;
      arr_lane[d] = (2'(d) == cfg_i.axis) ? 16'd0 : lane16(cfg_i.array_strides, 2'(d));
      if (active[d] && carry) begin
        if (({1'b0, coord_q[d]} + 17'd1) >= {1'b0, ext[d]}) begin
          coord_n[d] = '0;
          idx_dlt[d] = '0 - rewind(ext_m1[d], lane16(cfg_i.index_strides, 2'(d)));
          str_dlt[d] = '0 - rewind(ext_m1[d], lane16(cfg_i.stream_strides, 2'(d)));
          arr_dlt[d] = '0 - rewind(ext_m1[d], arr_lane[d]);
        end else begin
          coord_n[d] = coord_q[d] + 16'd1;
          idx_dlt[d] = to_ofs(lane16(cfg_i.index_strides, 2'(d)));
          str_dlt[d] = to_ofs(lane16(cfg_i.stream_strides, 2'(d)));
          arr_dlt[d] = to_ofs(arr_lane[d]);
          carry = 1'b0;
        end
      end
    end
    done = carry;
    idx_pos_n  = idx_pos_q;
    str_pos_n  = str_pos_q;
    arr_base_n = arr_base_q;
    for (int d = 0; d < MAX_RANK; d++) begin
      idx_pos_n  = idx_pos_n + idx_dlt[d];
      str_pos_n  = str_pos_n + str_dlt[d];
      arr_base_n = arr_base_n + arr_dlt[d];
    end
  end

  always_comb begin
    res_o = '0;
    res_o.status = gsagu_pkg::STATUS_OK;
    if (is_start) begin
      res_o.last = empty;
    end else if (!running_q) begin
      res_o.status = gsagu_pkg::STATUS_IDLE;
    end else if (!in_range) begin
      res_o.status      = gsagu_pkg::STATUS_RANGE;
      res_o.last        = 1'b1;
      res_o.error_index = raw_index_i;
    end else begin
      res_o.transfer_valid = 1'b1;
      res_o.array_offset   = out_ofs(arr_base_q + prod_w[OB-1:0]);
      res_o.stream_offset  = out_ofs(str_pos_q);
      res_o.last           = done;
      res_o.index_offset   = done ? 32'd0 : out_ofs(idx_pos_n);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= 1'b0;
      idx_pos_q  <= '0;
      str_pos_q  <= '0;
      arr_base_q <= '0;
      for (int d = 0; d < MAX_RANK; d++) begin
        coord_q[d] <= '0;
      end
    end else if (step_i) begin
      if (is_start) begin
        running_q  <= !empty;
        idx_pos_q  <= '0;
        str_pos_q  <= '0;
        arr_base_q <= '0;
        for (int d = 0; d < MAX_RANK; d++) begin
          coord_q[d] <= '0;
        end
      end else if (running_q) begin
        if (in_range) begin
          running_q  <= !done;
          idx_pos_q  <= idx_pos_n;
          str_pos_q  <= str_pos_n;
          arr_base_q <= arr_base_n;
          for (int d = 0; d < MAX_RANK; d++) begin
            coord_q[d] <= coord_n[d];
          end
        end else begin
          running_q <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.last) |=> !running_q)
    else $error("job still running after its last request");

  a_hold_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (running_q && !step_i) |=> running_q)
    else $error("job stopped without a request");

  a_no_move_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !res_o.transfer_valid) |->
      (res_o.array_offset == 32'd0 && res_o.stream_offset == 32'd0))
    else $error("offsets set on a result without transfer");

  a_err_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_o.status != gsagu_pkg::STATUS_RANGE) |-> (res_o.error_index == 32'd0))
    else $error("error index set without range error");
`endif

endmodule

// ----- bench/gsagu_offset_checker.sv -----
// watches the request, result and register channels and checks every address set
module gsagu_offset_checker
  import gsagu_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  input  logic         s_axis_tready_o,
  input  logic [31:0]  s_axis_tdata_i,
  input  logic         s_axis_tuser_i,
  input  logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  input  logic [127:0] m_axis_tdata_o,
  input  logic [2:0]   m_axis_tuser_o,
  input  logic         m_axis_tlast_o,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  output int           fail_count_o,
  output int           pending_o,
  output int           result_count_o,
  output int           done_count_o,
  output int           range_count_o,
  output int           idle_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copy, take/put selection leaves the addresses alone
  bit [2:0]  rank_q;
  bit [1:0]  axis_q;
  bit [15:0] len_q;
  bit [63:0] shape_q;
  bit [63:0] astr_q;
  bit [63:0] istr_q;
  bit [63:0] sstr_q;

  // walk state
  bit [15:0] coord_q [4];
  bit [31:0] index_pos_q;
  bit [31:0] stream_pos_q;
  bit [31:0] array_base_q;
  bit        running_q;

  result_t address_set_q [$];
  result_t want;
  result_t got;

  function automatic bit [31:0] lane_s(bit [63:0] p, int d);
    return {{16{p[d*16+15]}}, p[d*16 +: 16]};
  endfunction

  function automatic void clear_walk();
    for (int d = 0; d < 4; d++) coord_q[d] = '0;
    index_pos_q  = '0;
    stream_pos_q = '0;
    array_base_q = '0;
  endfunction

  // odometer step, last dimension fastest; returns 1 once the walk wraps
  function automatic bit advance_walk(int r);
    int        d;
    bit [31:0] ext;
    bit [31:0] di;
    bit [31:0] ds;
    bit [31:0] db;
    bit [16:0] nxt;
    for (int k = r; k > 0; k--) begin
      d   = k - 1;
      ext = {16'b0, shape_q[d*16 +: 16]};
      di  = lane_s(istr_q, d);
      ds  = lane_s(sstr_q, d);
      db  = (d == int'(axis_q)) ? 32'd0 : lane_s(astr_q, d);
      nxt = {1'b0, coord_q[d]} + 17'd1;
      if ({15'b0, nxt} < ext) begin
        coord_q[d]   = nxt[15:0];
        index_pos_q  = index_pos_q + di;
        stream_pos_q = stream_pos_q + ds;
        array_base_q = array_base_q + db;
        return 1'b0;
      end
      // rewind this dimension and carry into the next slower one
      coord_q[d] = '0;
      if (ext != 0) ext = ext - 32'd1;
      index_pos_q  = index_pos_q - ext * di;
      stream_pos_q = stream_pos_q - ext * ds;
      array_base_q = array_base_q - ext * db;
    end
    return 1'b1;
  endfunction

  function automatic result_t next_address_set(kind_e kind, logic [31:0] raw);
    result_t   res;
    int        r;
    longint    v;
    bit        empty;
    bit [31:0] axs;
    res = '0;
    r   = (rank_q > 3'd4) ? 4 : int'(rank_q);
    if (kind == KIND_START) begin
      empty = (r == 0) || (len_q == 16'd0) || (int'(axis_q) >= r);
      for (int d = 0; d < r; d++)
        if (shape_q[d*16 +: 16] == 16'd0) empty = 1'b1;
      clear_walk();
      running_q = !empty;
      res.last  = empty;
    end else if (!running_q) begin
      res.status = STATUS_IDLE;
    end else begin
      v = {{32{raw[31]}}, raw};
      if (v < 0) v = v + longint'(len_q);
      if (v < 0 || v >= longint'(len_q)) begin
        res.status      = STATUS_RANGE;
        res.last        = 1'b1;
        res.error_index = raw;
        running_q       = 1'b0;
      end else begin
        axs                = lane_s(astr_q, int'(axis_q));
        res.array_offset   = array_base_q + v[31:0] * axs;
        res.stream_offset  = stream_pos_q;
        res.transfer_valid = 1'b1;
        if (advance_walk(r)) begin
          res.last  = 1'b1;
          running_q = 1'b0;
        end else begin
          res.index_offset = index_pos_q;
        end
      end
    end
    return res;
  endfunction

  function automatic int field_diff(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q         = '0;
      axis_q         = '0;
      len_q          = '0;
      shape_q        = '0;
      astr_q         = '0;
      istr_q         = '0;
      sstr_q         = '0;
      running_q      = 1'b0;
      clear_walk();
      address_set_q.delete();
      pending_o      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (reg_e'(cfg_index_i))
          REG_GATHER_MODE:    ;
          REG_RANK:           rank_q  = cfg_data_i[2:0];
          REG_AXIS:           axis_q  = cfg_data_i[1:0];
          REG_AXIS_LENGTH:    len_q   = cfg_data_i[15:0];
          REG_WALK_SHAPE:     shape_q = cfg_data_i;
          REG_ARRAY_STRIDES:  astr_q  = cfg_data_i;
          REG_INDEX_STRIDES:  istr_q  = cfg_data_i;
          REG_STREAM_STRIDES: sstr_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (address_set_q.size() == 0) begin
          $error("address set delivered with no request waiting");
          fail_count_o++;
        end else begin
          want = address_set_q.pop_front();
          got.index_offset   = m_axis_tdata_o[31:0];
          got.array_offset   = m_axis_tdata_o[63:32];
          got.stream_offset  = m_axis_tdata_o[95:64];
          got.error_index    = m_axis_tdata_o[127:96];
          got.transfer_valid = m_axis_tuser_o[0];
          got.status         = status_e'(m_axis_tuser_o[2:1]);
          got.last           = m_axis_tlast_o;
          fail_count_o += field_diff("index_offset", want.index_offset, got.index_offset);
          fail_count_o += field_diff("array_offset", want.array_offset, got.array_offset);
          fail_count_o += field_diff("stream_offset", want.stream_offset, got.stream_offset);
          fail_count_o += field_diff("transfer_valid", 32'(want.transfer_valid),
                                     32'(got.transfer_valid));
          fail_count_o += field_diff("last", 32'(want.last), 32'(got.last));
          fail_count_o += field_diff("status", 32'(want.status), 32'(got.status));
          fail_count_o += field_diff("error_index", want.error_index, got.error_index);
          result_count_o++;
          if (want.transfer_valid && want.last) done_count_o++;
          if (want.status == STATUS_RANGE) range_count_o++;
          if (want.status == STATUS_IDLE) idle_count_o++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        address_set_q.push_back(next_address_set(kind_e'(s_axis_tuser_i), s_axis_tdata_i));
      pending_o = address_set_q.size();
    end
  end

endmodule

// ----- bench/tb_gather_scatter_along_axis_agu_unit.sv -----
// top of the address generator testbench: clock, reset, stimulus and verdict
module tb_gather_scatter_along_axis_agu_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import gsagu_pkg::*;

  localparam int HOLD_CYCLES = 60;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 40;
  localparam int MAX_JOB     = 24;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;

  int fails;
  int pending;
  int results;
  int done_jobs;
  int range_errs;
  int idle_reqs;
  int sent;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gather_scatter_along_axis_agu_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  gsagu_offset_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fails),
    .pending_o       (pending),
    .result_count_o  (results),
    .done_count_o    (done_jobs),
    .range_count_o   (range_errs),
    .idle_count_o    (idle_reqs)
  );

  function automatic logic [63:0] lanes(logic [15:0] l0, logic [15:0] l1,
                                        logic [15:0] l2, logic [15:0] l3);
    return {l3, l2, l1, l0};
  endfunction

  function automatic logic [15:0] pick_extent();
    case ($urandom_range(29))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(4, 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_stride();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    int   er;
    c = '0;
    case ($urandom_range(9))
      0:       c.rank = 3'd0;
      1:       c.rank = 3'($urandom_range(7, 5));
      default: c.rank = 3'($urandom_range(4, 1));
    endcase
    er = (c.rank > 3'd4) ? 4 : int'(c.rank);
    c.axis = (er > 0 && $urandom_range(9) != 0) ? 2'($urandom_range(er - 1))
                                                : 2'($urandom_range(3));
    case ($urandom_range(19))
      0:       c.axis_length = 16'd0;
      1:       c.axis_length = 16'hFFFF;
      2, 3, 4: c.axis_length = 16'($urandom);
      default: c.axis_length = 16'($urandom_range(8, 1));
    endcase
    for (int d = 0; d < 4; d++) begin
      c.walk_shape[d*16 +: 16]     = (d < er) ? pick_extent() : 16'($urandom);
      c.array_strides[d*16 +: 16]  = pick_stride();
      c.index_strides[d*16 +: 16]  = pick_stride();
      c.stream_strides[d*16 +: 16] = pick_stride();
    end
    return c;
  endfunction

  // number of index requests a full walk takes, capped so jobs stay short
  function automatic int walk_length(cfg_t c);
    int     er;
    longint prod;
    er   = (c.rank > 3'd4) ? 4 : int'(c.rank);
    prod = 1;
    for (int d = 0; d < er; d++) prod = prod * longint'(c.walk_shape[d*16 +: 16]);
    return (prod > MAX_JOB) ? MAX_JOB : int'(prod);
  endfunction

  function automatic logic [31:0] pick_index(logic [15:0] len);
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'($urandom);
      3:       return {16'b0, len};
      default: begin
        if (len == 16'd0) return 32'($urandom);
        if ($urandom_range(1)) return 32'($urandom_range(len - 16'd1));
        return 32'd0 - 32'($urandom_range(len, 1));
      end
    endcase
  endfunction

  task automatic cfg_put(reg_e idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(bit mode, cfg_t c);
    cfg_put(REG_GATHER_MODE, {63'b0, mode});
    cfg_put(REG_RANK, {61'b0, c.rank});
    cfg_put(REG_AXIS, {62'b0, c.axis});
    cfg_put(REG_AXIS_LENGTH, {48'b0, c.axis_length});
    cfg_put(REG_WALK_SHAPE, c.walk_shape);
    cfg_put(REG_ARRAY_STRIDES, c.array_strides);
    cfg_put(REG_INDEX_STRIDES, c.index_strides);
    cfg_put(REG_STREAM_STRIDES, c.stream_strides);
    cfg_valid <= 1'b0;
  endtask

  task automatic send(kind_e kind, logic [31:0] raw);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < 37) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= raw;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // stop offering and wait until every address set is back
  task automatic drain();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= !idle_on || ($urandom_range(99) >= 37);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    cfg_t c;
    int   n;
    int   count;
    bit   paused;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 2-d walk along dimension 1, extreme strides, unused extents at max
    c = '0;
    c.rank           = 3'd2;
    c.axis           = 2'd1;
    c.axis_length    = 16'd5;
    c.walk_shape     = lanes(16'd2, 16'd3, 16'hFFFF, 16'hFFFF);
    c.array_strides  = lanes(16'h7FFF, 16'h8000, 16'd3, 16'd4);
    c.index_strides  = lanes(16'd3, 16'd1, 16'd0, 16'hFFFF);
    c.stream_strides = lanes(16'h8000, 16'h0000, 16'h7FFF, 16'd1);
    load_config(1'b0, c);
    send(KIND_INDEX, 32'h7FFF_FFFF);
    send(KIND_START, 32'h0);
    send(KIND_INDEX, 32'd0);
    send(KIND_INDEX, 32'hFFFF_FFFF);
    send(KIND_INDEX, 32'd4);
    send(KIND_INDEX, 32'hFFFF_FFFB);
    send(KIND_INDEX, 32'd5);
    send(KIND_INDEX, 32'h8000_0000);
    send(KIND_START, 32'hFFFF_FFFF);
    send(KIND_START, 32'h0);
    send(KIND_INDEX, 32'd1);
    send(KIND_INDEX, 32'd2);
    send(KIND_INDEX, 32'd3);
    send(KIND_INDEX, 32'hFFFF_FFFE);
    send(KIND_INDEX, 32'd0);
    send(KIND_INDEX, 32'd4);
    send(KIND_START, 32'h0);
    send(KIND_INDEX, 32'h8000_0000);

    // oversized rank, longest axis, every extent at max
    drain();
    c.rank        = 3'd7;
    c.axis        = 2'd3;
    c.axis_length = 16'hFFFF;
    c.walk_shape  = lanes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    load_config(1'b1, c);
    send(KIND_START, 32'h0);
    send(KIND_INDEX, 32'd65534);
    send(KIND_INDEX, 32'hFFFF_0001);
    send(KIND_INDEX, 32'd65535);

    // empty jobs: no rank, axis outside rank, zero length, zero extent
    drain();
    c.rank = 3'd0;
    load_config(1'b0, c);
    send(KIND_START, 32'h0);
    drain();
    c.rank = 3'd2;
    load_config(1'b1, c);
    send(KIND_START, 32'h0);
    drain();
    c.axis        = 2'd0;
    c.axis_length = 16'd0;
    load_config(1'b0, c);
    send(KIND_START, 32'h0);
    drain();
    c.axis_length = 16'd3;
    c.walk_shape  = lanes(16'd4, 16'd0, 16'd1, 16'd1);
    load_config(1'b1, c);
    send(KIND_START, 32'h0);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      c = random_cfg();
      load_config(1'($urandom_range(1)), c);
      idle_on = !(phase == 6 || phase == 7);
      if (phase == 2) hold_req = 1'b1;
      count  = 0;
      paused = 1'b0;
      while (count < PHASE_ITEMS) begin
        if (phase == 4 && !paused && count > PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 85) begin
          send(KIND_START, 32'($urandom));
          n = walk_length(c);
          if ($urandom_range(9) == 0) n = $urandom_range(n);
          for (int i = 0; i < n; i++)
            send(KIND_INDEX, ($urandom_range(19) == 0) ? pick_index(c.axis_length)
                 : (c.axis_length == 16'd0) ? 32'($urandom)
                 : 32'($urandom_range(c.axis_length - 16'd1)));
          count += n + 1;
        end else begin
          send(kind_e'($urandom_range(1)),
               $urandom_range(1) ? 32'($urandom) : pick_index(c.axis_length));
          count++;
        end
      end
    end
    idle_on = 1'b1;

    drain();
    repeat (10) @(posedge clk);
    if (pending != 0) $error("%0d address sets never arrived", pending);
    $display("covered %0d requests, %0d address sets checked over %0d register settings",
             sent, results, PHASES + 6);
    $display("%0d walks ran to the end, %0d index range errors, %0d requests while idle",
             done_jobs, range_errs, idle_reqs);
    if (fails == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
